// ===== sv/tsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsgd_pkg
// Types and constants shared by the simple glyph decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package tsgd_pkg;

   localparam int MAX_POINTS   = 1024;
   localparam int MAX_CONTOURS = 64;

   // point store address width and point count width
   localparam int PT_AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PTC_W  = PT_AW + 1;
   // contour end store address width and contour count width
   localparam int CT_AW  = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;
   localparam int CTC_W  = CT_AW + 1;

   // flag byte bit positions
   localparam int FL_ON_BIT     = 0;
   localparam int FL_XSHORT_BIT = 1;
   localparam int FL_YSHORT_BIT = 2;
   localparam int FL_REPEAT_BIT = 3;
   localparam int FL_XSAME_BIT  = 4;
   localparam int FL_YSAME_BIT  = 5;

   typedef enum logic [1:0] {
      ST_POINT    = 2'd0,
      ST_COMPOUND = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_COUNT_LO,
      S_BBOX,
      S_ENDS,
      S_ILEN,
      S_INSTR,
      S_FLAGS,
      S_REPEAT,
      S_RFILL,
      S_XFETCH,
      S_XCHK,
      S_XC,
      S_YFETCH,
      S_YCHK,
      S_YC,
      S_DRAIN,
      S_EMIT0,
      S_EMIT1
   } state_type;

   typedef struct packed {
      logic [7:0]  flag;
      logic [15:0] x;
      logic [15:0] y;
   } point_word_type;

   typedef struct packed {
      logic [PT_AW-1:0] addr;
      logic             we_flag;
      logic             we_x;
      logic             we_y;
      logic [7:0]       flag;
      logic [15:0]      coord;
   } pt_wr_type;

endpackage

`default_nettype wire

// ===== sv/tsgd_if.sv =====
// ----------------------------------------------------------------------------
// tsgd_if
// Valid/ready channels for glyph bytes in and decoded points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsgd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       glyph_start;
   modport source (output valid, output data_byte, output glyph_start, input ready);
   modport sink   (input valid, input data_byte, input glyph_start, output ready);
endinterface

interface tsgd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_coord;
   logic signed [15:0] y_coord;
   logic               on_curve;
   logic               contour_end;
   logic               last_point;
   logic [1:0]         status;
   modport source (output valid, output x_coord, output y_coord, output on_curve,
                   output contour_end, output last_point, output status, input ready);
   modport sink   (input valid, input x_coord, input y_coord, input on_curve,
                   input contour_end, input last_point, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/tsgd_point_store.sv =====
// ----------------------------------------------------------------------------
// tsgd_point_store
// Per-point memory: flag, x and y fields, field write enables, two read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgd_point_store (
   input  wire logic                         clock,
   input  wire tsgd_pkg::pt_wr_type          wr,
   input  wire logic [tsgd_pkg::PT_AW-1:0]   ra_addr,
   input  wire logic [tsgd_pkg::PT_AW-1:0]   rb_addr,
   output tsgd_pkg::point_word_type          ra_data,
   output tsgd_pkg::point_word_type          rb_data
);

   tsgd_pkg::point_word_type pmem [tsgd_pkg::MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr.we_flag) begin
         pmem[wr.addr].flag <= wr.flag;
      end
      if (wr.we_x) begin
         pmem[wr.addr].x <= wr.coord;
      end
      if (wr.we_y) begin
         pmem[wr.addr].y <= wr.coord;
      end
   end

   always_ff @(posedge clock) begin
      ra_data <= pmem[ra_addr];
      rb_data <= pmem[rb_addr];
   end

endmodule

`default_nettype wire

// ===== sv/truetype_simple_glyph_decoder.sv =====
// ----------------------------------------------------------------------------
// truetype_simple_glyph_decoder
// Byte-serial decoder of simple glyph outlines into absolute points.
// ----------------------------------------------------------------------------
// Feed the glyph record one byte per transaction, glyph_start high on the
// first byte. A repeat count byte also expands the repeated flag into the
// point store, and an x byte that completes a coordinate also fills in each
// following point whose x needs no byte; a y byte likewise fills in skipped
// points. Every coordinate and emitted point passes through the registered
// read of the point store. Each y or trailing byte gives at most one point,
// oldest first, so after the last y byte the source sends filler bytes until
// the point with last_point set appears. A result waiting in the output
// register does not hold up bytes that cannot produce one.
`default_nettype none

module truetype_simple_glyph_decoder (
   input  wire logic   clock,
   input  wire logic   reset,
   tsgd_req_if.sink    req_bus,
   tsgd_rsp_if.source  rsp_bus
);

   localparam int PT_AW = tsgd_pkg::PT_AW;
   localparam int PTC_W = tsgd_pkg::PTC_W;
   localparam int CT_AW = tsgd_pkg::CT_AW;
   localparam int CTC_W = tsgd_pkg::CTC_W;

   // parser state
   tsgd_pkg::state_type state_ff, state_in;
   logic [15:0]      cnt_ff, cnt_in;          // byte counter / high byte toggle
   logic [7:0]       hold_ff, hold_in;        // high byte of a 16-bit field
   logic [CTC_W-1:0] ctotal_ff, ctotal_in;
   logic [PTC_W-1:0] ptotal_ff, ptotal_in;
   logic [PTC_W-1:0] pidx_ff, pidx_in;        // flag/x position, then emit position
   logic [PTC_W-1:0] ypar_ff, ypar_in;        // y parse position
   logic [CTC_W-1:0] cidx_ff, cidx_in;
   logic [15:0]      coord_ff, coord_in;      // running coordinate, wraps
   logic [7:0]       curflag_ff, curflag_in;  // flag of the coordinate in progress
   logic [7:0]       lastflag_ff, lastflag_in;
   logic [7:0]       rep_ff, rep_in;
   logic             yemit_ff, yemit_in;      // y skip follows a byte, so emit after

   // contour end store
   logic [15:0]      ends_mem [tsgd_pkg::MAX_CONTOURS];
   logic [15:0]      ends_rd_ff;
   logic             ends_we;

   // point store
   tsgd_pkg::pt_wr_type      wr;
   logic [PT_AW-1:0]         ra_addr, rb_addr;
   tsgd_pkg::point_word_type ra_data, rb_data;

   // output register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_on_ff, rsp_ce_ff, rsp_last_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_load, slot_free;
   logic [15:0]        res_x, res_y;
   logic               res_on, res_ce, res_last;
   tsgd_pkg::status_type res_status;

   // byte handshake
   logic        taking, take, accept;
   logic [7:0]  b;
   logic [15:0] v;
   logic [16:0] v_ext;

   // coordinate datapath
   logic        c_short, c_pos, c_done;
   logic [15:0] c_delta, c_sum;
   logic [7:0]  fl;
   logic [PTC_W-1:0] pidx_nx, ypar_nx;

   assign b       = req_bus.data_byte;
   assign v       = {hold_ff, b};
   assign v_ext   = {1'b0, v};
   assign fl      = ra_data.flag;
   assign pidx_nx = pidx_ff + 1'b1;
   assign ypar_nx = ypar_ff + 1'b1;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // states that wait for a byte; only the count and end index bytes can
   // produce a result in the cycle they are taken
   always_comb begin
      unique case (state_ff)
         tsgd_pkg::S_IDLE, tsgd_pkg::S_BBOX, tsgd_pkg::S_ILEN, tsgd_pkg::S_INSTR,
         tsgd_pkg::S_FLAGS, tsgd_pkg::S_REPEAT, tsgd_pkg::S_XC, tsgd_pkg::S_YC,
         tsgd_pkg::S_DRAIN: taking = 1'b1;
         tsgd_pkg::S_COUNT_LO, tsgd_pkg::S_ENDS: taking = slot_free;
         default: taking = 1'b0;
      endcase
   end

   assign req_bus.ready = taking;
   assign accept        = req_bus.valid && taking;
   assign take          = accept && !req_bus.glyph_start;

   // short delta or long 16-bit delta into the running coordinate
   assign c_short = (state_ff == tsgd_pkg::S_XC) ? curflag_ff[tsgd_pkg::FL_XSHORT_BIT]
                                                 : curflag_ff[tsgd_pkg::FL_YSHORT_BIT];
   assign c_pos   = (state_ff == tsgd_pkg::S_XC) ? curflag_ff[tsgd_pkg::FL_XSAME_BIT]
                                                 : curflag_ff[tsgd_pkg::FL_YSAME_BIT];
   assign c_delta = c_short ? (c_pos ? {8'h00, b} : (16'd0 - {8'h00, b})) : v;
   assign c_sum   = coord_ff + c_delta;
   assign c_done  = c_short || cnt_ff[0];

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      hold_in     = hold_ff;
      ctotal_in   = ctotal_ff;
      ptotal_in   = ptotal_ff;
      pidx_in     = pidx_ff;
      ypar_in     = ypar_ff;
      cidx_in     = cidx_ff;
      coord_in    = coord_ff;
      curflag_in  = curflag_ff;
      lastflag_in = lastflag_ff;
      rep_in      = rep_ff;
      yemit_in    = yemit_ff;

      wr          = '0;
      wr.addr     = pidx_ff[PT_AW-1:0];
      wr.flag     = b;
      wr.coord    = c_sum;
      ra_addr     = pidx_ff[PT_AW-1:0];
      rb_addr     = pidx_ff[PT_AW-1:0];
      ends_we     = 1'b0;

      rsp_load    = 1'b0;
      res_x       = '0;
      res_y       = '0;
      res_on      = 1'b0;
      res_ce      = 1'b0;
      res_last    = 1'b1;
      res_status  = tsgd_pkg::ST_POINT;

      unique case (state_ff)
         tsgd_pkg::S_IDLE: begin
         end
         tsgd_pkg::S_COUNT_LO: begin
            if (take) begin
               if (v[15]) begin
                  // compound glyph
                  rsp_load   = 1'b1;
                  res_status = tsgd_pkg::ST_COMPOUND;
                  state_in   = tsgd_pkg::S_IDLE;
               end else if (v > 16'(tsgd_pkg::MAX_CONTOURS)) begin
                  rsp_load   = 1'b1;
                  res_status = tsgd_pkg::ST_OVERFLOW;
                  state_in   = tsgd_pkg::S_IDLE;
               end else begin
                  ctotal_in = v[CTC_W-1:0];
                  ptotal_in = '0;
                  cnt_in    = '0;
                  state_in  = tsgd_pkg::S_BBOX;
               end
            end
         end
         tsgd_pkg::S_BBOX: begin
            if (take) begin
               if (cnt_ff >= 16'd7) begin
                  cnt_in   = '0;
                  state_in = (ctotal_ff != '0) ? tsgd_pkg::S_ENDS : tsgd_pkg::S_ILEN;
               end else begin
                  cnt_in = cnt_ff + 16'd1;
               end
            end
         end
         tsgd_pkg::S_ENDS: begin
            if (take) begin
               if (!cnt_ff[0]) begin
                  hold_in = b;
                  cnt_in  = cnt_ff + 16'd1;
               end else begin
                  ends_we = 1'b1;
                  if (({1'b0, cnt_ff[15:1]} + 16'd1) >= 16'(ctotal_ff)) begin
                     if (v_ext >= 17'(tsgd_pkg::MAX_POINTS)) begin
                        // last end index leaves no room in the point store
                        rsp_load   = 1'b1;
                        res_status = tsgd_pkg::ST_OVERFLOW;
                        state_in   = tsgd_pkg::S_IDLE;
                     end else begin
                        ptotal_in = PTC_W'(v_ext + 17'd1);
                        cnt_in    = '0;
                        state_in  = tsgd_pkg::S_ILEN;
                     end
                  end else begin
                     cnt_in = cnt_ff + 16'd1;
                  end
               end
            end
         end
         tsgd_pkg::S_ILEN: begin
            if (take) begin
               if (cnt_ff == '0) begin
                  hold_in = b;
                  cnt_in  = 16'd1;
               end else if (v == '0) begin
                  cnt_in   = '0;
                  pidx_in  = '0;
                  state_in = (ptotal_ff == '0) ? tsgd_pkg::S_IDLE : tsgd_pkg::S_FLAGS;
               end else begin
                  cnt_in   = v;
                  state_in = tsgd_pkg::S_INSTR;
               end
            end
         end
         tsgd_pkg::S_INSTR: begin
            if (take) begin
               cnt_in = (cnt_ff == '0) ? '0 : cnt_ff - 16'd1;
               if (cnt_ff <= 16'd1) begin
                  pidx_in  = '0;
                  state_in = (ptotal_ff == '0) ? tsgd_pkg::S_IDLE : tsgd_pkg::S_FLAGS;
               end
            end
         end
         tsgd_pkg::S_FLAGS: begin
            if (take) begin
               wr.we_flag  = 1'b1;
               pidx_in     = pidx_nx;
               lastflag_in = b;
               if (b[tsgd_pkg::FL_REPEAT_BIT]) begin
                  state_in = tsgd_pkg::S_REPEAT;
               end else if (pidx_nx >= ptotal_ff) begin
                  pidx_in  = '0;
                  coord_in = '0;
                  cnt_in   = '0;
                  state_in = tsgd_pkg::S_XFETCH;
               end
            end
         end
         tsgd_pkg::S_REPEAT: begin
            if (take) begin
               if (pidx_ff >= ptotal_ff) begin
                  pidx_in  = '0;
                  coord_in = '0;
                  cnt_in   = '0;
                  state_in = tsgd_pkg::S_XFETCH;
               end else if (b == '0) begin
                  state_in = tsgd_pkg::S_FLAGS;
               end else begin
                  rep_in   = b;
                  state_in = tsgd_pkg::S_RFILL;
               end
            end
         end
         tsgd_pkg::S_RFILL: begin
            // copy the repeated flag, one entry a cycle
            wr.we_flag = 1'b1;
            wr.flag    = lastflag_ff;
            pidx_in    = pidx_nx;
            rep_in     = rep_ff - 8'd1;
            if (pidx_nx >= ptotal_ff) begin
               pidx_in  = '0;
               coord_in = '0;
               cnt_in   = '0;
               state_in = tsgd_pkg::S_XFETCH;
            end else if (rep_ff == 8'd1) begin
               state_in = tsgd_pkg::S_FLAGS;
            end
         end
         tsgd_pkg::S_XFETCH: begin
            state_in = tsgd_pkg::S_XCHK;
         end
         tsgd_pkg::S_XCHK: begin
            if (pidx_ff >= ptotal_ff) begin
               // x done, start on y
               ypar_in  = '0;
               pidx_in  = '0;
               cidx_in  = '0;
               coord_in = '0;
               cnt_in   = '0;
               yemit_in = 1'b0;
               state_in = tsgd_pkg::S_YFETCH;
            end else if (!fl[tsgd_pkg::FL_XSHORT_BIT] && fl[tsgd_pkg::FL_XSAME_BIT]) begin
               // x same as previous, no byte
               wr.we_x  = 1'b1;
               wr.coord = coord_ff;
               pidx_in  = pidx_nx;
               ra_addr  = pidx_nx[PT_AW-1:0];
            end else begin
               curflag_in = fl;
               state_in   = tsgd_pkg::S_XC;
            end
         end
         tsgd_pkg::S_XC: begin
            if (take) begin
               if (!c_done) begin
                  hold_in = b;
                  cnt_in  = 16'd1;
               end else begin
                  coord_in = c_sum;
                  cnt_in   = '0;
                  wr.we_x  = 1'b1;
                  pidx_in  = pidx_nx;
                  ra_addr  = pidx_nx[PT_AW-1:0];
                  state_in = tsgd_pkg::S_XCHK;
               end
            end
         end
         tsgd_pkg::S_YFETCH: begin
            ra_addr  = ypar_ff[PT_AW-1:0];
            state_in = tsgd_pkg::S_YCHK;
         end
         tsgd_pkg::S_YCHK: begin
            wr.addr = ypar_ff[PT_AW-1:0];
            if (ypar_ff >= ptotal_ff) begin
               state_in = yemit_ff ? tsgd_pkg::S_EMIT0 : tsgd_pkg::S_DRAIN;
            end else if (!fl[tsgd_pkg::FL_YSHORT_BIT] && fl[tsgd_pkg::FL_YSAME_BIT]) begin
               wr.we_y  = 1'b1;
               wr.coord = coord_ff;
               ypar_in  = ypar_nx;
               ra_addr  = ypar_nx[PT_AW-1:0];
            end else begin
               curflag_in = fl;
               state_in   = yemit_ff ? tsgd_pkg::S_EMIT0 : tsgd_pkg::S_YC;
            end
         end
         tsgd_pkg::S_YC: begin
            wr.addr = ypar_ff[PT_AW-1:0];
            if (take) begin
               if (!c_done) begin
                  hold_in  = b;
                  cnt_in   = 16'd1;
                  state_in = tsgd_pkg::S_EMIT0;
               end else begin
                  coord_in = c_sum;
                  cnt_in   = '0;
                  wr.we_y  = 1'b1;
                  ypar_in  = ypar_nx;
                  ra_addr  = ypar_nx[PT_AW-1:0];
                  yemit_in = 1'b1;
                  state_in = tsgd_pkg::S_YCHK;
               end
            end
         end
         tsgd_pkg::S_DRAIN: begin
            if (take) begin
               state_in = tsgd_pkg::S_EMIT0;
            end
         end
         tsgd_pkg::S_EMIT0: begin
            if (pidx_ff < ypar_ff && pidx_ff < ptotal_ff) begin
               state_in = tsgd_pkg::S_EMIT1;
            end else begin
               state_in = (ypar_ff >= ptotal_ff) ? tsgd_pkg::S_DRAIN : tsgd_pkg::S_YC;
            end
         end
         tsgd_pkg::S_EMIT1: begin
            // point word is in rb_data, contour end in ends_rd_ff
            if (slot_free) begin
               rsp_load   = 1'b1;
               res_x      = rb_data.x;
               res_y      = rb_data.y;
               res_on     = rb_data.flag[tsgd_pkg::FL_ON_BIT];
               res_ce     = (cidx_ff < ctotal_ff) && (ends_rd_ff == 16'(pidx_ff));
               res_last   = (pidx_nx == ptotal_ff);
               pidx_in    = pidx_nx;
               if (res_ce) begin
                  cidx_in = cidx_ff + 1'b1;
               end
               if (res_last) begin
                  state_in = tsgd_pkg::S_IDLE;
               end else begin
                  state_in = (ypar_ff >= ptotal_ff) ? tsgd_pkg::S_DRAIN : tsgd_pkg::S_YC;
               end
            end
         end
         default: begin
            state_in = tsgd_pkg::S_IDLE;
         end
      endcase

      // a new record overrides whatever the phase was doing
      if (accept && req_bus.glyph_start) begin
         hold_in  = b;
         state_in = tsgd_pkg::S_COUNT_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsgd_pkg::S_IDLE;
         cnt_ff   <= '0;
         pidx_ff  <= '0;
         ypar_ff  <= '0;
         cidx_ff  <= '0;
         rep_ff   <= '0;
         yemit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pidx_ff  <= pidx_in;
         ypar_ff  <= ypar_in;
         cidx_ff  <= cidx_in;
         rep_ff   <= rep_in;
         yemit_ff <= yemit_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      ctotal_ff   <= ctotal_in;
      ptotal_ff   <= ptotal_in;
      coord_ff    <= coord_in;
      curflag_ff  <= curflag_in;
      lastflag_ff <= lastflag_in;
   end

   // contour end store, read continuously at the current contour
   always_ff @(posedge clock) begin
      if (ends_we) begin
         ends_mem[cnt_ff[CT_AW:1]] <= v;
      end
      ends_rd_ff <= ends_mem[cidx_ff[CT_AW-1:0]];
   end

   tsgd_point_store u_point_store (
      .clock   (clock),
      .wr      (wr),
      .ra_addr (ra_addr),
      .rb_addr (rb_addr),
      .ra_data (ra_data),
      .rb_data (rb_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_bus.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff      <= res_x;
         rsp_y_ff      <= res_y;
         rsp_on_ff     <= res_on;
         rsp_ce_ff     <= res_ce;
         rsp_last_ff   <= res_last;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.x_coord     = rsp_x_ff;
   assign rsp_bus.y_coord     = rsp_y_ff;
   assign rsp_bus.on_curve    = rsp_on_ff;
   assign rsp_bus.contour_end = rsp_ce_ff;
   assign rsp_bus.last_point  = rsp_last_ff;
   assign rsp_bus.status      = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // a point is only read out once its y has been parsed
   a_emit_parsed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsgd_pkg::S_EMIT1) |-> (pidx_ff < ypar_ff))
      else $error("emitting a point whose y is not parsed");

   // an error result ends the record
   a_error_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_status != tsgd_pkg::ST_POINT) |=> (state_ff == tsgd_pkg::S_IDLE))
      else $error("parser kept going after an error result");

   // an error result always closes the stream with last_point set
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !res_last) |-> (res_status == tsgd_pkg::ST_POINT))
      else $error("error result without last_point");
`endif

endmodule

`default_nettype wire
